@@ design/ihm_pkg.sv @@
// Shared types, codes and constants of the IMU sample health monitor.
package ihm_pkg;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_FAIL   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  localparam logic [1:0] REG_GYRO_FS  = 2'd0;
  localparam logic [1:0] REG_PERIOD   = 2'd1;
  localparam logic [1:0] REG_HIGH_G   = 2'd2;
  localparam logic [1:0] REG_MAX_FAIL = 2'd3;

  localparam logic [17:0] GYRO_LIM_SCALE    = 18'd42;
  localparam logic [15:0] DEFAULT_PERIOD_US = 16'd5000;
  localparam logic [15:0] ONE_G             = 16'd2048;
  localparam logic [36:0] LOW_G_SQ25        = 37'd1048576;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] g2;
    logic [31:0] a2;
    logic [15:0] dt;
  } in_stage_t;

  typedef struct packed {
    logic [35:0] lim_sq;
    logic [31:0] hi_sq;
    logic [22:0] lo_sq;
    logic        under_en;
    logic [15:0] per;
    logic [7:0]  max_fail;
  } cfg_t;

  typedef struct packed {
    logic [7:0] failure_run;
    logic       anomaly;
    logic       high_g;
    logic       sensor_ok;
    logic       fault;
  } flags_t;

  typedef struct packed {
    logic gyro_ok;
    logic fuse_accel;
    logic fault_now;
  } verdict_t;

  localparam flags_t FLAGS_RESET = '{
    failure_run: 8'd0,
    anomaly:     1'b0,
    high_g:      1'b0,
    sensor_ok:   1'b1,
    fault:       1'b0
  };

  function automatic logic [30:0] sq16(input logic signed [15:0] v);
    logic signed [31:0] p;
    p = $signed({{16{v[15]}}, v}) * $signed({{16{v[15]}}, v});
    return p[30:0];
  endfunction

endpackage

@@ design/imu_sample_health_monitor.sv @@
// Top level of the IMU sample health monitor: input stage, state, result register.
//
//  Channel  Direction  Beat contents
//  s_*      in         tuser: command; tdata: gyro x/y/z, accel x/y/z, dt_us
//  m_*      out        tdata: verdict bits, latched flags, failure run, event counts
//  cfg_*    in         register index and write data, no read-back
//
// One beat is taken every cycle unless a waiting result holds up the input register.
// The squared magnitudes are formed on entry to the input register, the checks and
// the state update between the input register and the result register.
// Synchronous reset restores the flags, counters and config registers; the derived
// thresholds are registered from the config registers and follow a write or a reset.
// While the result waits, the input register holds one further beat before s_tready drops.
module imu_sample_health_monitor #(
  parameter int EVENT_COUNT_WIDTH = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [15:0] gyro_x, [31:16] gyro_y, [47:32] gyro_z, [63:48] accel_x,
  // [79:64] accel_y, [95:80] accel_z, [111:96] dt_us
  input  logic [111:0] s_tdata,
  // [1:0] command
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [0] gyro_ok, [1] fuse_accel, [2] fault_now, [3] flag_anomaly,
  // [4] flag_high_g_reject, [5] flag_sensor_ok, [6] flag_fault,
  // [14:7] consecutive_failures, [30:15] high_g_events, [46:31] anomaly_events,
  // [62:47] jitter_events, [63] zero
  output logic [63:0]  m_tdata,
  input  logic         cfg_wen,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  function automatic logic [15:0] rep16(input logic [EVENT_COUNT_WIDTH-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
  endfunction

  logic [17:0]  gyro_lim;
  logic [15:0]  per;
  logic [14:0]  high_g_thr;
  logic [7:0]   max_fail;
  ihm_pkg::cfg_t cfg;
  logic [15:0]  hi_w;
  logic [15:0]  lo_w;

  logic                 in_valid;
  ihm_pkg::in_stage_t   in_q;
  logic                 advance;
  logic                 in_accept;

  ihm_pkg::flags_t              flags;
  ihm_pkg::flags_t              flags_next;
  logic [EVENT_COUNT_WIDTH-1:0] high_g_cnt;
  logic [EVENT_COUNT_WIDTH-1:0] anomaly_cnt;
  logic [EVENT_COUNT_WIDTH-1:0] jitter_cnt;
  logic [EVENT_COUNT_WIDTH-1:0] high_g_cnt_next;
  logic [EVENT_COUNT_WIDTH-1:0] anomaly_cnt_next;
  logic [EVENT_COUNT_WIDTH-1:0] jitter_cnt_next;
  ihm_pkg::verdict_t            verdict;

  logic              out_valid;
  ihm_pkg::verdict_t out_verdict;
  ihm_pkg::flags_t   out_flags;
  logic [15:0]       out_high_g;
  logic [15:0]       out_anomaly;
  logic [15:0]       out_jitter;

  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_lim   <= 18'd84000;
      per        <= ihm_pkg::DEFAULT_PERIOD_US;
      high_g_thr <= 15'd1024;
      max_fail   <= 8'd5;
    end else if (cfg_wen) begin
      case (cfg_index)
        ihm_pkg::REG_GYRO_FS:  gyro_lim <= {6'b0, cfg_data[11:0]} * ihm_pkg::GYRO_LIM_SCALE;
        ihm_pkg::REG_PERIOD:   per <= (cfg_data == 16'd0) ? ihm_pkg::DEFAULT_PERIOD_US
                                                          : cfg_data;
        ihm_pkg::REG_HIGH_G:   high_g_thr <= cfg_data[14:0];
        ihm_pkg::REG_MAX_FAIL: max_fail <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  assign hi_w = ihm_pkg::ONE_G + {1'b0, high_g_thr};
  assign lo_w = ihm_pkg::ONE_G - {1'b0, high_g_thr};

  always_ff @(posedge clk) begin
    cfg.lim_sq   <= 36'(gyro_lim) * 36'(gyro_lim);
    cfg.hi_sq    <= 32'(hi_w) * 32'(hi_w);
    cfg.lo_sq    <= 23'(lo_w[11:0]) * 23'(lo_w[11:0]);
    cfg.under_en <= {1'b0, high_g_thr} <= ihm_pkg::ONE_G;
    cfg.per      <= per;
    cfg.max_fail <= max_fail;
  end

  assign advance   = in_valid && (!out_valid || m_tready);
  assign s_tready  = !rst && (!in_valid || advance);
  assign in_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_accept) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_q.cmd <= ihm_pkg::cmd_t'(s_tuser);
      in_q.g2  <= 32'(ihm_pkg::sq16(s_tdata[15:0])) + 32'(ihm_pkg::sq16(s_tdata[31:16]))
                + 32'(ihm_pkg::sq16(s_tdata[47:32]));
      in_q.a2  <= 32'(ihm_pkg::sq16(s_tdata[63:48])) + 32'(ihm_pkg::sq16(s_tdata[79:64]))
                + 32'(ihm_pkg::sq16(s_tdata[95:80]));
      in_q.dt  <= s_tdata[111:96];
    end
  end

  ihm_eval #(
    .EVENT_COUNT_WIDTH(EVENT_COUNT_WIDTH)
  ) u_eval (
    .item             (in_q),
    .cfg              (cfg),
    .flags            (flags),
    .high_g_cnt       (high_g_cnt),
    .anomaly_cnt      (anomaly_cnt),
    .jitter_cnt       (jitter_cnt),
    .flags_next       (flags_next),
    .high_g_cnt_next  (high_g_cnt_next),
    .anomaly_cnt_next (anomaly_cnt_next),
    .jitter_cnt_next  (jitter_cnt_next),
    .verdict          (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      flags       <= ihm_pkg::FLAGS_RESET;
      high_g_cnt  <= '0;
      anomaly_cnt <= '0;
      jitter_cnt  <= '0;
    end else if (advance) begin
      flags       <= flags_next;
      high_g_cnt  <= high_g_cnt_next;
      anomaly_cnt <= anomaly_cnt_next;
      jitter_cnt  <= jitter_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_verdict <= verdict;
      out_flags   <= flags_next;
      out_high_g  <= rep16(high_g_cnt_next);
      out_anomaly <= rep16(anomaly_cnt_next);
      out_jitter  <= rep16(jitter_cnt_next);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_jitter, out_anomaly, out_high_g, out_flags.failure_run,
                     out_flags.fault, out_flags.sensor_ok, out_flags.high_g,
                     out_flags.anomaly, out_verdict.fault_now,
                     out_verdict.fuse_accel, out_verdict.gyro_ok};

  a_fault_now_latched: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_verdict.fault_now |-> out_flags.fault && !out_flags.sensor_ok)
    else $error("Hard fault reported without the latched fault flag.");

  a_verdict_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_verdict.fault_now
                    && (out_verdict.gyro_ok || out_verdict.fuse_accel)))
    else $error("Read failure verdict mixed with a sample verdict.");

  a_fuse_clears_high_g: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_verdict.fuse_accel |-> !out_flags.high_g && out_flags.sensor_ok)
    else $error("Accel fused while the high-g reject flag is set.");

  a_clear_restores: assert property (@(posedge clk) disable iff (rst)
    advance && in_q.cmd == ihm_pkg::CMD_CLEAR
      |=> flags == ihm_pkg::FLAGS_RESET && high_g_cnt == '0 && anomaly_cnt == '0
          && jitter_cnt == '0)
    else $error("Clear beat did not restore the monitor state.");

endmodule

@@ design/ihm_eval.sv @@
// Per-item evaluation: gyro range, interval jitter, accel gating and failure tracking.
module ihm_eval #(
  parameter int EVENT_COUNT_WIDTH = 16
) (
  input  ihm_pkg::in_stage_t       item,
  input  ihm_pkg::cfg_t            cfg,
  input  ihm_pkg::flags_t          flags,
  input  logic [EVENT_COUNT_WIDTH-1:0] high_g_cnt,
  input  logic [EVENT_COUNT_WIDTH-1:0] anomaly_cnt,
  input  logic [EVENT_COUNT_WIDTH-1:0] jitter_cnt,
  output ihm_pkg::flags_t          flags_next,
  output logic [EVENT_COUNT_WIDTH-1:0] high_g_cnt_next,
  output logic [EVENT_COUNT_WIDTH-1:0] anomaly_cnt_next,
  output logic [EVENT_COUNT_WIDTH-1:0] jitter_cnt_next,
  output ihm_pkg::verdict_t        verdict
);

  localparam logic [EVENT_COUNT_WIDTH-1:0] CNT_ONE = {{(EVENT_COUNT_WIDTH-1){1'b0}}, 1'b1};

  function automatic logic [EVENT_COUNT_WIDTH-1:0] bump(
    input logic [EVENT_COUNT_WIDTH-1:0] c
  );
    return (&c) ? c : c + CNT_ONE;
  endfunction

  logic [36:0] g2_x25;
  logic [36:0] a2_x25;
  logic        gyro_over;
  logic        jitter;
  logic        low_g;
  logic        accel_over;
  logic        accel_under;
  logic [7:0]  run_inc;

  assign g2_x25 = {item.g2, 5'b0} - {2'b0, item.g2, 3'b0} + {5'b0, item.g2};
  assign a2_x25 = {item.a2, 5'b0} - {2'b0, item.a2, 3'b0} + {5'b0, item.a2};

  assign gyro_over   = g2_x25 > {1'b0, cfg.lim_sq};
  assign jitter      = ({1'b0, item.dt} > {cfg.per, 1'b0})
                    || (({3'b0, item.dt} + {1'b0, item.dt, 2'b0}) < {3'b0, cfg.per});
  assign low_g       = a2_x25 < ihm_pkg::LOW_G_SQ25;
  assign accel_over  = item.a2 >= cfg.hi_sq;
  assign accel_under = cfg.under_en && (item.a2 <= {9'b0, cfg.lo_sq});
  assign run_inc     = (&flags.failure_run) ? flags.failure_run : flags.failure_run + 8'd1;

  always_comb begin
    flags_next       = flags;
    high_g_cnt_next  = high_g_cnt;
    anomaly_cnt_next = anomaly_cnt;
    jitter_cnt_next  = jitter_cnt;
    verdict          = '0;
    case (item.cmd)
      ihm_pkg::CMD_SAMPLE: begin
        verdict.gyro_ok = 1'b1;
        if (gyro_over) begin
          verdict.gyro_ok    = 1'b0;
          anomaly_cnt_next   = bump(anomaly_cnt);
          flags_next.anomaly = 1'b1;
        end
        if (jitter) begin
          jitter_cnt_next    = bump(jitter_cnt);
          flags_next.anomaly = 1'b1;
        end
        if (low_g) begin
          flags_next.high_g = 1'b1;
        end else if (accel_over || accel_under) begin
          high_g_cnt_next   = bump(high_g_cnt);
          flags_next.high_g = 1'b1;
        end else begin
          flags_next.high_g  = 1'b0;
          verdict.fuse_accel = 1'b1;
        end
        flags_next.failure_run = 8'd0;
        flags_next.sensor_ok   = 1'b1;
      end
      ihm_pkg::CMD_FAIL: begin
        flags_next.failure_run = run_inc;
        flags_next.sensor_ok   = 1'b0;
        if (run_inc >= cfg.max_fail) begin
          flags_next.fault  = 1'b1;
          verdict.fault_now = 1'b1;
        end
      end
      ihm_pkg::CMD_CLEAR: begin
        flags_next       = ihm_pkg::FLAGS_RESET;
        high_g_cnt_next  = '0;
        anomaly_cnt_next = '0;
        jitter_cnt_next  = '0;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ tb/sv/ihm_health_checker.sv @@
`timescale 1ns / 100ps
// Result checker of the IMU sample health monitor: predicts each result beat and compares it.
module ihm_health_checker
  import ihm_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [111:0] s_tdata,
  input  logic [1:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [63:0]  m_tdata,
  input  logic         cfg_wen,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  output int           mismatches,
  output int           outstanding
);

  typedef struct {
    logic        gyro_ok;
    logic        fuse_accel;
    logic        fault_now;
    logic        anomaly;
    logic        high_g;
    logic        sensor_ok;
    logic        fault;
    logic [7:0]  failure_run;
    logic [15:0] high_g_events;
    logic [15:0] anomaly_events;
    logic [15:0] jitter_events;
  } health_t;

  health_t health_due[$];
  health_t wanted;
  int      beats_seen;

  logic [11:0] fs_dps;
  logic [15:0] period_us;
  logic [14:0] high_g_thr;
  logic [7:0]  fail_limit;

  logic [7:0]  run_len;
  logic [15:0] high_g_count;
  logic [15:0] anomaly_count;
  logic [15:0] jitter_count;
  logic        anomaly_flag;
  logic        high_g_flag;
  logic        sensor_ok_flag;
  logic        fault_flag;

  initial begin
    mismatches  = 0;
    outstanding = 0;
    beats_seen  = 0;
  end

  function automatic logic [15:0] bump_count(logic [15:0] c);
    return (c == 16'hFFFF) ? c : c + 16'd1;
  endfunction

  function automatic longint mag_sq(logic [47:0] v);
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    x = v[15:0];
    y = v[31:16];
    z = v[47:32];
    return longint'(x) * longint'(x) + longint'(y) * longint'(y) + longint'(z) * longint'(z);
  endfunction

  task automatic clear_health();
    run_len         = '0;
    high_g_count    = '0;
    anomaly_count   = '0;
    jitter_count    = '0;
    anomaly_flag    = 1'b0;
    high_g_flag     = 1'b0;
    sensor_ok_flag  = 1'b1;
    fault_flag      = 1'b0;
  endtask

  task automatic predict_health(input logic [1:0] cmd, input logic [111:0] d,
                                output health_t r);
    longint g2;
    longint a2;
    longint dt;
    longint lim;
    longint per;
    longint hi;
    longint lo;
    logic   over;
    logic   under;
    r = '{default: '0};
    case (cmd)
      CMD_SAMPLE: begin
        g2  = mag_sq(d[47:0]);
        a2  = mag_sq(d[95:48]);
        dt  = longint'(d[111:96]);
        lim = longint'(GYRO_LIM_SCALE) * longint'(fs_dps);
        per = (period_us == '0) ? longint'(DEFAULT_PERIOD_US) : longint'(period_us);
        r.gyro_ok = 1'b1;
        if (25 * g2 > lim * lim) begin
          r.gyro_ok     = 1'b0;
          anomaly_count = bump_count(anomaly_count);
          anomaly_flag  = 1'b1;
        end
        if (dt > 2 * per || 5 * dt < per) begin
          jitter_count = bump_count(jitter_count);
          anomaly_flag = 1'b1;
        end
        if (25 * a2 < longint'(LOW_G_SQ25)) begin
          high_g_flag = 1'b1;
        end else begin
          hi    = longint'(ONE_G) + longint'(high_g_thr);
          lo    = longint'(ONE_G) - longint'(high_g_thr);
          over  = (a2 >= hi * hi);
          under = (lo >= 0) && (a2 <= lo * lo);
          if (over || under) begin
            high_g_count = bump_count(high_g_count);
            high_g_flag  = 1'b1;
          end else begin
            high_g_flag  = 1'b0;
            r.fuse_accel = 1'b1;
          end
        end
        run_len        = '0;
        sensor_ok_flag = 1'b1;
      end
      CMD_FAIL: begin
        if (run_len != 8'hFF) run_len = run_len + 8'd1;
        sensor_ok_flag = 1'b0;
        if (run_len >= fail_limit) begin
          fault_flag  = 1'b1;
          r.fault_now = 1'b1;
        end
      end
      CMD_CLEAR: clear_health();
      default: ;
    endcase
    r.anomaly        = anomaly_flag;
    r.high_g         = high_g_flag;
    r.sensor_ok      = sensor_ok_flag;
    r.fault          = fault_flag;
    r.failure_run    = run_len;
    r.high_g_events  = high_g_count;
    r.anomaly_events = anomaly_count;
    r.jitter_events  = jitter_count;
  endtask

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                beats_seen, name, got, want));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_health();
      fs_dps     = 12'd2000;
      period_us  = DEFAULT_PERIOD_US;
      high_g_thr = 15'd1024;
      fail_limit = 8'd5;
      health_due.delete();
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          REG_GYRO_FS:  fs_dps     = cfg_data[11:0];
          REG_PERIOD:   period_us  = cfg_data;
          REG_HIGH_G:   high_g_thr = cfg_data[14:0];
          REG_MAX_FAIL: fail_limit = cfg_data[7:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        predict_health(s_tuser, s_tdata, wanted);
        health_due.push_back(wanted);
      end
      if (m_tvalid && m_tready) begin
        if (health_due.size() == 0) begin
          report_mismatch($sformatf("result beat %h with nothing expected", m_tdata));
        end else begin
          wanted = health_due.pop_front();
          compare_field("gyro_ok", m_tdata[0], wanted.gyro_ok);
          compare_field("fuse_accel", m_tdata[1], wanted.fuse_accel);
          compare_field("fault_now", m_tdata[2], wanted.fault_now);
          compare_field("flag_anomaly", m_tdata[3], wanted.anomaly);
          compare_field("flag_high_g_reject", m_tdata[4], wanted.high_g);
          compare_field("flag_sensor_ok", m_tdata[5], wanted.sensor_ok);
          compare_field("flag_fault", m_tdata[6], wanted.fault);
          compare_field("consecutive_failures", m_tdata[14:7], wanted.failure_run);
          compare_field("high_g_events", m_tdata[30:15], wanted.high_g_events);
          compare_field("anomaly_events", m_tdata[46:31], wanted.anomaly_events);
          compare_field("jitter_events", m_tdata[62:47], wanted.jitter_events);
          compare_field("padding", m_tdata[63], 1'b0);
        end
        beats_seen++;
      end
    end
    outstanding <= health_due.size();
  end

endmodule

@@ tb/sv/tb_imu_sample_health_monitor.sv @@
`timescale 1ns / 100ps
// Testbench top of the IMU sample health monitor: clock, reset, stimulus and verdict.
module tb_imu_sample_health_monitor;
  import ihm_pkg::*;

  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int         CYCLE_LIMIT = 600000;

  logic         clk       = 1'b0;
  logic         rst       = 1'b1;
  logic         s_tvalid  = 1'b0;
  logic         s_tready;
  logic [111:0] s_tdata   = '0;
  logic [1:0]   s_tuser   = CMD_SAMPLE;
  logic         m_tvalid;
  logic         m_tready  = 1'b0;
  logic [63:0]  m_tdata;
  logic         cfg_wen   = 1'b0;
  logic [1:0]   cfg_index = REG_GYRO_FS;
  logic [15:0]  cfg_data  = '0;

  int mismatches;
  int outstanding;
  int cycles     = 0;
  int send_idle  = 0;
  int recv_idle  = 0;
  int fs_now     = 2000;
  int period_now = 5000;
  int thr_now    = 1024;

  always #10 clk = ~clk;

  imu_sample_health_monitor u_top (.*);
  ihm_health_checker u_checker (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) m_tready <= !rst && (int'($urandom_range(99)) >= recv_idle);

  function automatic logic [15:0] signed_mag(int mag);
    int m;
    m = (mag < 0) ? -mag : mag;
    if (m > 32767) m = 32767;
    return $urandom_range(1) ? 16'(-m) : 16'(m);
  endfunction

  function automatic logic [47:0] random_gyro();
    logic [15:0] g [3];
    int          axis;
    axis = $urandom_range(2);
    case ($urandom_range(3))
      0: foreach (g[i]) g[i] = 16'($urandom);
      1: foreach (g[i]) g[i] = signed_mag($urandom_range(fs_now * 8));
      default: begin
        foreach (g[i]) g[i] = signed_mag($urandom_range(3));
        g[axis] = signed_mag(42 * fs_now / 5 + int'($urandom_range(6)) - 3);
      end
    endcase
    return {g[2], g[1], g[0]};
  endfunction

  function automatic logic [47:0] random_accel();
    logic [15:0] a [3];
    int          axis;
    int          jig;
    axis = $urandom_range(2);
    jig  = int'($urandom_range(4)) - 2;
    foreach (a[i]) a[i] = signed_mag($urandom_range(1));
    case ($urandom_range(5))
      0: foreach (a[i]) a[i] = 16'($urandom);
      1: a[axis] = signed_mag(2048 + thr_now + jig);
      2: a[axis] = signed_mag(2048 - thr_now + jig);
      3: a[axis] = signed_mag(205 + jig);
      default: a[axis] = signed_mag(2048 + int'($urandom_range(2 * thr_now)) - thr_now);
    endcase
    return {a[2], a[1], a[0]};
  endfunction

  function automatic logic [15:0] random_dt();
    int per;
    int v;
    per = (period_now == 0) ? 5000 : period_now;
    case ($urandom_range(4))
      0: v = int'($urandom_range(65535));
      1: v = 2 * per + int'($urandom_range(4)) - 2;
      2: v = per / 5 + int'($urandom_range(4)) - 2;
      default: v = per / 2 + int'($urandom_range(per));
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  function automatic logic [111:0] random_payload();
    return 112'({$urandom(), $urandom(), $urandom(), $urandom()});
  endfunction

  task automatic send_beat(input logic [1:0] cmd, input logic [111:0] payload);
    while (int'($urandom_range(99)) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= payload;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_sample(input logic [47:0] gyro, input logic [47:0] accel,
                             input logic [15:0] dt);
    send_beat(CMD_SAMPLE, {dt, accel, gyro});
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int val);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 16'(val);
    @(posedge clk);
  endtask

  task automatic set_config(input int fs, input int period, input int thr, input int max_fails);
    wait_drained();
    write_reg(REG_GYRO_FS, fs);
    write_reg(REG_PERIOD, period);
    write_reg(REG_HIGH_G, thr);
    write_reg(REG_MAX_FAIL, max_fails);
    cfg_wen <= 1'b0;
    repeat (2) @(posedge clk);
    fs_now     = fs;
    period_now = period;
    thr_now    = thr;
  endtask

  task automatic run_random(input int items);
    int sent;
    int pick;
    int burst;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(99) == 0) wait_drained();
      pick = $urandom_range(99);
      if (pick < 78) begin
        send_sample(random_gyro(), random_accel(), random_dt());
        sent++;
      end else if (pick < 92) begin
        burst = ($urandom_range(39) == 0) ? 256 + int'($urandom_range(3))
                                          : int'($urandom_range(8, 1));
        repeat (burst) send_beat(CMD_FAIL, random_payload());
        sent += burst;
      end else if (pick < 97) begin
        send_beat(CMD_CLEAR, random_payload());
        sent++;
      end else begin
        send_beat(CMD_UNUSED, random_payload());
      end
    end
  endtask

  initial begin
    send_idle = 37;
    recv_idle = 71;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    send_sample({3{16'd0}}, {16'd0, 16'd0, 16'd2048}, 16'd5000);
    send_sample({16'd0, 16'd0, 16'd16800}, {16'd0, 16'd2047, 16'd0}, 16'd10000);
    send_sample({16'd0, 16'd0, 16'd16801}, {16'd0, 16'd0, 16'd3072}, 16'd10001);
    send_sample({3{16'h8000}}, {3{16'h7FFF}}, 16'hFFFF);
    send_sample({3{16'h7FFF}}, {3{16'h8000}}, 16'd0);
    send_sample({3{16'd0}}, {16'd0, 16'd0, 16'd3071}, 16'd1000);
    send_sample({3{16'd0}}, {16'd0, 16'd0, 16'd1024}, 16'd999);
    send_sample({3{16'd0}}, {16'd0, 16'd0, 16'd1025}, 16'd5000);
    send_sample({3{16'd0}}, {16'd0, 16'd0, 16'hFF33}, 16'd5000);
    send_sample({3{16'd0}}, {16'd204, 16'd0, 16'd0}, 16'd5000);
    repeat (6) send_beat(CMD_FAIL, random_payload());
    send_sample({3{16'd0}}, {16'd0, 16'd0, 16'd2048}, 16'd5000);
    send_beat(CMD_UNUSED, random_payload());
    send_beat(CMD_CLEAR, random_payload());
    send_beat(CMD_FAIL, random_payload());

    set_config(4000, 0, 0, 0);
    send_beat(CMD_FAIL, random_payload());
    send_sample({16'd0, 16'd0, 16'd32767}, {16'd0, 16'd2048, 16'd0}, 16'd5000);
    send_sample({3{16'd0}}, {16'd0, 16'd0, 16'd2049}, 16'd5000);
    run_random(520);

    set_config(0, 65535, 32767, 255);
    send_idle = 71;
    recv_idle = 37;
    send_sample({3{16'd0}}, {16'd0, 16'd0, 16'd2048}, 16'd13107);
    send_sample({16'd0, 16'd1, 16'd0}, {16'd0, 16'd0, 16'd2048}, 16'd13106);
    run_random(520);

    set_config($urandom_range(4000), $urandom_range(65535, 1), $urandom_range(4096),
               $urandom_range(16, 1));
    send_idle = 0;
    recv_idle = 0;
    run_random(520);

    // Drive the failure run into saturation.
    set_config(0, 100, 0, 255);
    repeat (260) send_beat(CMD_FAIL, random_payload());
    set_config(2000, 5000, 1024, 5);
    run_random(40);

    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
design/ihm_pkg.sv
design/ihm_eval.sv
design/imu_sample_health_monitor.sv
tb/sv/ihm_health_checker.sv
tb/sv/tb_imu_sample_health_monitor.sv
